@@ hdl/svm_pkg.sv @@
`timescale 1ns / 1ps
package svm_pkg;

    localparam int REG_COUNT = 5;
    localparam int LINK_REG  = 4;

    // Operation codes.
    localparam logic [4:0] OP_MOVE  = 5'd0;
    localparam logic [4:0] OP_PUSH  = 5'd1;
    localparam logic [4:0] OP_POP   = 5'd2;
    localparam logic [4:0] OP_PUSHA = 5'd3;
    localparam logic [4:0] OP_POPA  = 5'd4;
    localparam logic [4:0] OP_ADD   = 5'd5;
    localparam logic [4:0] OP_SUB   = 5'd6;
    localparam logic [4:0] OP_MUL   = 5'd7;
    localparam logic [4:0] OP_DIV   = 5'd8;
    localparam logic [4:0] OP_INC   = 5'd9;
    localparam logic [4:0] OP_DEC   = 5'd10;
    localparam logic [4:0] OP_CMP   = 5'd11;
    localparam logic [4:0] OP_JMP   = 5'd12;
    localparam logic [4:0] OP_JEQ   = 5'd13;
    localparam logic [4:0] OP_JNE   = 5'd14;
    localparam logic [4:0] OP_JLT   = 5'd15;
    localparam logic [4:0] OP_JLE   = 5'd16;
    localparam logic [4:0] OP_JGT   = 5'd17;
    localparam logic [4:0] OP_JGE   = 5'd18;
    localparam logic [4:0] OP_CALL  = 5'd19;
    localparam logic [4:0] OP_RET   = 5'd20;

    // Operand kinds.
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_VAR = 2'd1;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OVER  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_DEST  = 3'd4;

    // Divider request and status between top level and divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

@@ hdl/stack_vm_execute_unit.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Fields (tdata from bit 0)                         | Handshake
// s_axis  | in  | op, first_kind, first_value, second_kind, second_value | tvalid/tready
// m_axis  | out | next_pc, status, wrote, written_value              | tvalid/tready
// One item is worked at a time through a small sequencer over the variable and stack memories.
// Each item passes through READ, EXEC and OUT; PUSHA and POPA add a state with one stack access a cycle,
// and DIV waits in DIVW for the 32-step divider.
// After reset the block sweeps the variable memory to zero before taking items.
// A result waits in the output register; the next item is taken once it has been delivered.
module stack_vm_execute_unit
#(
    parameter int STACK_DEPTH    = 256,
    parameter int VARIABLE_SLOTS = 64,
    parameter int PC_WIDTH       = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[4:0], first_kind[6:5], first_value[38:7], second_kind[40:39],
    // second_value[72:41], zero fill
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[PC_WIDTH-1:0], status, wrote, written_value, zero fill
    output logic [((PC_WIDTH + 36 + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import svm_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VARIABLE_SLOTS > 1) ? $clog2(VARIABLE_SLOTS) : 1;
    localparam int OW = ((PC_WIDTH + 36 + 7) / 8) * 8;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_READ  = 8'b00000100,
        S_EXEC  = 8'b00001000,
        S_DIVW  = 8'b00010000,
        S_PUSHA = 8'b00100000,
        S_POPA  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] regs_reg [REG_COUNT];
    logic [31:0] var_mem [VARIABLE_SLOTS];
    logic [31:0] stk_mem [STACK_DEPTH];
    logic [31:0] var_q1, var_q2, stk_q;

    logic [DW-1:0] depth_reg;
    logic [31:0]   cmp_reg;
    logic [PC_WIDTH-1:0] pc_reg;
    logic [VW-1:0] clr_reg;
    logic [2:0]    idx_reg;

    logic [4:0]  op_reg;
    logic [1:0]  fk_reg, sk_reg;
    logic [31:0] fv_reg, sv_reg;

    logic [PC_WIDTH-1:0] onpc_reg;
    logic [2:0]  ost_reg;
    logic        owr_reg;
    logic [31:0] oval_reg;
    logic        ovalid_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    svm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Operand decode.
    logic f_reg_ok, f_var_ok, s_reg_ok, s_var_ok, dest_op, dest_ok;
    assign f_reg_ok = (fk_reg == KIND_REG) && (fv_reg < 32'(REG_COUNT));
    assign f_var_ok = (fk_reg == KIND_VAR) && (fv_reg < 32'(VARIABLE_SLOTS));
    assign s_reg_ok = (sk_reg == KIND_REG) && (sv_reg < 32'(REG_COUNT));
    assign s_var_ok = (sk_reg == KIND_VAR) && (sv_reg < 32'(VARIABLE_SLOTS));
    assign dest_op  = (op_reg == OP_MOVE) || (op_reg == OP_POP)
                   || ((op_reg >= OP_ADD) && (op_reg <= OP_DEC));
    assign dest_ok  = f_reg_ok || f_var_ok;

    logic [31:0] a_val, b_val;
    always_comb
    begin
        if (fk_reg == KIND_REG)
            a_val = f_reg_ok ? regs_reg[fv_reg[2:0]] : 32'd0;
        else if (fk_reg == KIND_VAR)
            a_val = f_var_ok ? var_q1 : 32'd0;
        else
            a_val = fv_reg;
        if (sk_reg == KIND_REG)
            b_val = s_reg_ok ? regs_reg[sv_reg[2:0]] : 32'd0;
        else if (sk_reg == KIND_VAR)
            b_val = s_var_ok ? var_q2 : 32'd0;
        else
            b_val = sv_reg;
    end

    // Execute-stage result.
    logic [PC_WIDTH-1:0] pc_inc;
    logic [2:0]  ex_st;
    logic        ex_wr, take;
    logic [31:0] ex_val;
    logic [PC_WIDTH-1:0] ex_pc;
    logic signed [31:0] cs;
    assign pc_inc = pc_reg + 1'b1;
    assign cs     = cmp_reg;

    always_comb
    begin
        ex_st  = ST_OK;
        ex_wr  = 1'b0;
        ex_val = '0;
        ex_pc  = pc_inc;
        take   = 1'b0;
        case (op_reg)
            OP_JMP: take = 1'b1;
            OP_JEQ: take = (cs == 0);
            OP_JNE: take = (cs != 0);
            OP_JLT: take = (cs < 0);
            OP_JLE: take = (cs <= 0);
            OP_JGT: take = (cs > 0);
            OP_JGE: take = (cs >= 0);
            default: take = 1'b0;
        endcase
        if (dest_op && !dest_ok)
            ex_st = ST_DEST;
        else
        begin
            case (op_reg)
                OP_MOVE: begin ex_wr = 1'b1; ex_val = b_val; end
                OP_PUSH: if (depth_reg == DW'(STACK_DEPTH)) ex_st = ST_OVER;
                OP_POP:
                    if (depth_reg == '0) ex_st = ST_UNDER;
                    else begin ex_wr = 1'b1; ex_val = stk_q; end
                OP_PUSHA:
                    if (32'(depth_reg) + 32'(REG_COUNT) > 32'(STACK_DEPTH))
                        ex_st = ST_OVER;
                OP_POPA: if (depth_reg < DW'(REG_COUNT)) ex_st = ST_UNDER;
                OP_ADD:  begin ex_wr = 1'b1; ex_val = a_val + b_val; end
                OP_SUB:  begin ex_wr = 1'b1; ex_val = a_val - b_val; end
                OP_MUL:  begin ex_wr = 1'b1; ex_val = a_val * b_val; end
                OP_DIV:  if (b_val == 32'd0) ex_st = ST_DIV0;
                OP_INC:  begin ex_wr = 1'b1; ex_val = a_val + 32'd1; end
                OP_DEC:  begin ex_wr = 1'b1; ex_val = a_val - 32'd1; end
                OP_JMP, OP_JEQ, OP_JNE, OP_JLT, OP_JLE, OP_JGT, OP_JGE:
                    if (take) ex_pc = a_val[PC_WIDTH-1:0];
                OP_CALL:
                begin
                    ex_wr  = 1'b1;
                    ex_val = 32'(pc_reg) + 32'd1;
                    ex_pc  = a_val[PC_WIDTH-1:0];
                end
                OP_RET: ex_pc = regs_reg[LINK_REG][PC_WIDTH-1:0] + 1'b1;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == VW'(VARIABLE_SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:  if (in_acc) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:
                if (ex_st != ST_OK) state_next = S_OUT;
                else if (op_reg == OP_DIV) state_next = S_DIVW;
                else if (op_reg == OP_PUSHA) state_next = S_PUSHA;
                else if (op_reg == OP_POPA) state_next = S_POPA;
                else state_next = S_OUT;
            S_DIVW:  if (drsp.done) state_next = S_OUT;
            S_PUSHA: if (idx_reg == 3'(REG_COUNT - 1)) state_next = S_OUT;
            S_POPA:  if (idx_reg == 3'(REG_COUNT)) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign dreq.start    = (state_reg == S_EXEC) && (ex_st == ST_OK) && (op_reg == OP_DIV);
    assign dreq.dividend = a_val;
    assign dreq.divisor  = b_val;

    // Final write value and destination.
    logic        fin_wr;
    logic [31:0] fin_val;
    always_comb
    begin
        fin_wr  = 1'b0;
        fin_val = '0;
        if (state_reg == S_EXEC && ex_st == ST_OK && ex_wr)
        begin
            fin_wr  = 1'b1;
            fin_val = ex_val;
        end
        else if (state_reg == S_DIVW && drsp.done)
        begin
            fin_wr  = 1'b1;
            fin_val = drsp.quotient;
        end
    end

    // Stack read address: the top entry, which during POPA moves down as the depth counts down.
    logic [SW-1:0] stk_raddr;
    assign stk_raddr = SW'(depth_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        var_q1 <= var_mem[fv_reg[VW-1:0]];
        var_q2 <= var_mem[sv_reg[VW-1:0]];
        stk_q  <= stk_mem[stk_raddr];
        if (state_reg == S_CLEAR)
            var_mem[clr_reg] <= '0;
        else if (fin_wr && fk_reg == KIND_VAR && op_reg != OP_CALL)
            var_mem[fv_reg[VW-1:0]] <= fin_val;
        if (state_reg == S_EXEC && ex_st == ST_OK && op_reg == OP_PUSH)
            stk_mem[depth_reg[SW-1:0]] <= a_val;
        else if (state_reg == S_PUSHA)
            stk_mem[depth_reg[SW-1:0]] <= regs_reg[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg <= s_axis_tdata[4:0];
            fk_reg <= s_axis_tdata[6:5];
            fv_reg <= s_axis_tdata[38:7];
            sk_reg <= s_axis_tdata[40:39];
            sv_reg <= s_axis_tdata[72:41];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            idx_reg    <= '0;
            depth_reg  <= '0;
            cmp_reg    <= '0;
            pc_reg     <= '0;
            ovalid_reg <= 1'b0;
            onpc_reg   <= '0;
            ost_reg    <= ST_OK;
            owr_reg    <= 1'b0;
            oval_reg   <= '0;
            for (int i = 0; i < REG_COUNT; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            // Register writes of single-result operations.
            if (fin_wr && op_reg == OP_CALL)
                regs_reg[LINK_REG] <= fin_val;
            else if (fin_wr && fk_reg == KIND_REG)
                regs_reg[fv_reg[2:0]] <= fin_val;
            if (state_reg == S_EXEC)
            begin
                idx_reg <= '0;
                onpc_reg <= ex_pc;
                ost_reg  <= ex_st;
                owr_reg  <= 1'b0;
                oval_reg <= '0;
                if (ex_st == ST_OK)
                begin
                    if (op_reg == OP_CMP)
                        cmp_reg <= b_val - a_val;
                    if (op_reg >= OP_JMP && op_reg <= OP_JGE)
                        cmp_reg <= '0;
                    if (op_reg == OP_PUSH)
                        depth_reg <= depth_reg + 1'b1;
                    if (op_reg == OP_POP)
                        depth_reg <= depth_reg - 1'b1;
                    owr_reg  <= ex_wr;
                    oval_reg <= ex_val;
                end
                else
                    onpc_reg <= pc_reg;
            end
            if (state_reg == S_DIVW && drsp.done)
            begin
                owr_reg  <= 1'b1;
                oval_reg <= drsp.quotient;
            end
            if (state_reg == S_PUSHA)
            begin
                idx_reg   <= idx_reg + 1'b1;
                depth_reg <= depth_reg + 1'b1;
            end
            // POPA: with idx_reg at zero it waits for the first read; then one register per cycle.
            if (state_reg == S_POPA)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg != '0)
                    regs_reg[3'(REG_COUNT) - idx_reg] <= stk_q;
                if (idx_reg < 3'(REG_COUNT))
                    depth_reg <= depth_reg - 1'b1;
                if (idx_reg == 3'(REG_COUNT))
                begin
                    owr_reg  <= 1'b1;
                    oval_reg <= stk_q;
                end
            end
            if (state_reg == S_OUT)
            begin
                ovalid_reg <= 1'b1;
                if (ost_reg == ST_OK)
                    pc_reg <= onpc_reg;
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = OW'({oval_reg, owr_reg, ost_reg, onpc_reg});

`ifndef SYNTH
    // A result never shows a fault status together with a write.
    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ost_reg != ST_OK) |-> !owr_reg)
        else $error("fault result reports a write");
    // Stack depth never exceeds its capacity.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth out of range");
    // No item is taken while a result is pending.
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");
`endif

endmodule

@@ hdl/svm_divider.sv @@
`timescale 1ns / 1ps
module svm_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  svm_pkg::div_req_t req,
    output svm_pkg::div_rsp_t rsp
);
    import svm_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    // One restoring step per cycle on magnitudes.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
            den_next  = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
            neg_next  = req.dividend[31] ^ req.divisor[31];
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import svm_pkg::*;

    localparam int STACK_N = 256;
    localparam int VAR_N   = 64;
    localparam int OUT_W   = ((16 + 36 + 7) / 8) * 8;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [79:0]      s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    // Fields from the highest bit down, as packed in m_axis_tdata.
    typedef struct packed {
        logic [31:0] written_value;
        logic        wrote;
        logic [2:0]  status;
        logic [15:0] next_pc;
    } vm_result_t;

    stack_vm_execute_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Machine state as the testbench sees it.
    logic [31:0] regs [REG_COUNT];
    logic [31:0] vars [VAR_N];
    logic [31:0] stk [STACK_N];
    int unsigned sp;
    logic [31:0] cmp_val;
    logic [15:0] pc;

    vm_result_t expected_results [$];
    int errors;
    int mismatches;
    bit sink_stall_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [31:0] fetch(logic [1:0] kind, logic [31:0] v);
        if (kind == KIND_REG)
            return (v < REG_COUNT) ? regs[v] : 32'd0;
        if (kind == KIND_VAR)
            return (v < VAR_N) ? vars[v] : 32'd0;
        return v;
    endfunction

    // Executes one instruction on the local state and returns its result.
    function automatic vm_result_t execute(logic [4:0] op, logic [1:0] fk, logic [31:0] fv,
                                           logic [1:0] sk, logic [31:0] sv);
        vm_result_t r;
        logic [15:0] nxt;
        logic [2:0] st;
        logic wr;
        logic [31:0] val;
        logic [31:0] dst;
        logic [31:0] b;
        bit has_dst;
        bit take;
        nxt = pc + 16'd1;
        st = ST_OK;
        wr = 1'b0;
        val = 32'd0;
        has_dst = 1'b0;
        dst = 32'd0;
        if (op == OP_MOVE || op == OP_POP || (op >= OP_ADD && op <= OP_DEC))
        begin
            if ((fk == KIND_REG && fv < REG_COUNT) || (fk == KIND_VAR && fv < VAR_N))
            begin
                has_dst = 1'b1;
                dst = fetch(fk, fv);
            end
            else
                st = ST_DEST;
        end
        if (st == ST_OK)
        begin
            case (op)
                OP_MOVE:
                begin
                    val = fetch(sk, sv);
                    wr = 1'b1;
                end
                OP_PUSH:
                    if (sp >= STACK_N) st = ST_OVER;
                    else
                    begin
                        stk[sp] = fetch(fk, fv);
                        sp++;
                    end
                OP_POP:
                    if (sp == 0) st = ST_UNDER;
                    else
                    begin
                        sp--;
                        val = stk[sp];
                        wr = 1'b1;
                    end
                OP_PUSHA:
                    if (sp + REG_COUNT > STACK_N) st = ST_OVER;
                    else
                        for (int i = 0; i < REG_COUNT; i++)
                        begin
                            stk[sp] = regs[i];
                            sp++;
                        end
                OP_POPA:
                    if (sp < REG_COUNT) st = ST_UNDER;
                    else
                    begin
                        for (int i = REG_COUNT - 1; i >= 0; i--)
                        begin
                            sp--;
                            regs[i] = stk[sp];
                        end
                        val = regs[0];
                        wr = 1'b1;
                    end
                OP_ADD: begin val = dst + fetch(sk, sv); wr = 1'b1; end
                OP_SUB: begin val = dst - fetch(sk, sv); wr = 1'b1; end
                OP_MUL: begin val = dst * fetch(sk, sv); wr = 1'b1; end
                OP_DIV:
                begin
                    b = fetch(sk, sv);
                    if (b == 0) st = ST_DIV0;
                    else if (dst == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                    begin
                        val = dst;
                        wr = 1'b1;
                    end
                    else
                    begin
                        val = $signed(dst) / $signed(b);
                        wr = 1'b1;
                    end
                end
                OP_INC: begin val = dst + 32'd1; wr = 1'b1; end
                OP_DEC: begin val = dst - 32'd1; wr = 1'b1; end
                OP_CMP: cmp_val = fetch(sk, sv) - fetch(fk, fv);
                OP_JMP, OP_JEQ, OP_JNE, OP_JLT, OP_JLE, OP_JGT, OP_JGE:
                begin
                    case (op)
                        OP_JMP: take = 1'b1;
                        OP_JEQ: take = (cmp_val == 0);
                        OP_JNE: take = (cmp_val != 0);
                        OP_JLT: take = ($signed(cmp_val) < 0);
                        OP_JLE: take = ($signed(cmp_val) <= 0);
                        OP_JGT: take = ($signed(cmp_val) > 0);
                        default: take = ($signed(cmp_val) >= 0);
                    endcase
                    b = fetch(fk, fv);
                    if (take) nxt = b[15:0];
                    cmp_val = 32'd0;
                end
                OP_CALL:
                begin
                    val = {16'd0, pc} + 32'd1;
                    b = fetch(fk, fv);
                    nxt = b[15:0];
                    regs[LINK_REG] = val;
                    wr = 1'b1;
                end
                OP_RET:
                begin
                    b = regs[LINK_REG] + 32'd1;
                    nxt = b[15:0];
                end
                default: ;
            endcase
        end
        if (st == ST_OK && has_dst && wr)
        begin
            if (fk == KIND_REG) regs[fv] = val;
            else vars[fv] = val;
        end
        if (st != ST_OK)
        begin
            nxt = pc;
            wr = 1'b0;
            val = 32'd0;
        end
        else
            pc = nxt;
        r.next_pc = nxt;
        r.status = st;
        r.wrote = wr;
        r.written_value = val;
        return r;
    endfunction

    // Drives one instruction after a random gap and records its expected result.
    task automatic send_instr(logic [4:0] op, logic [1:0] fk, logic [31:0] fv,
                              logic [1:0] sk, logic [31:0] sv);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        // The line stays idle at least through the falling edge after the last item.
        repeat (gap + 1) @(negedge clk);
        s_axis_tdata <= {7'd0, sv, sk, fv, fk, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_results.push_back(execute(op, fk, fv, sk, sv));
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Compares each delivered result with the oldest expectation.
    initial
    begin
        vm_result_t got;
        vm_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[51:0];
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want || m_axis_tdata[OUT_W-1:52] !== '0)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch exp/got: pc %0d/%0d st %0d/%0d wr %0d/%0d val %h/%h",
                                     want.next_pc, got.next_pc, want.status, got.status,
                                     want.wrote, got.wrote, want.written_value,
                                     got.written_value);
                    end
                end
            end
        end
    end

    // Result-side backpressure: a random wait before each item is taken while sink_stall_on is set.
    initial
    begin
        int w;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            w = sink_stall_on ? $urandom_range(0, 15) : 0;
            if (w != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    task automatic drain_results();
        while (expected_results.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 8);
            4: return $urandom_range(0, 70);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] dest_index(logic [1:0] kind);
        if (kind == KIND_REG) return $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 4);
        if (kind == KIND_VAR) return $urandom_range(0, 7) == 0 ? $urandom_range(64, 70)
                                                               : $urandom_range(0, VAR_N - 1);
        return rand_word();
    endfunction

    task automatic test_directed();
        send_instr(OP_POP, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_POPA, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_MOVE, 2'd2, 5, KIND_REG, 0);
        send_instr(OP_MOVE, 2'd3, 0, KIND_REG, 0);
        send_instr(OP_MOVE, KIND_REG, 5, 2'd2, 1);
        send_instr(OP_MOVE, KIND_VAR, 64, 2'd2, 1);
        send_instr(OP_MOVE, KIND_REG, 0, 2'd2, 32'h8000_0000);
        send_instr(OP_MOVE, KIND_VAR, 63, 2'd3, 32'hFFFF_FFFF);
        send_instr(OP_DIV, KIND_REG, 0, KIND_VAR, 63);
        send_instr(OP_DIV, KIND_REG, 0, 2'd2, 0);
        send_instr(OP_DIV, KIND_VAR, 63, 2'd2, 32'hFFFF_FFFD);
        send_instr(OP_ADD, KIND_REG, 1, KIND_REG, 7);
        send_instr(OP_SUB, KIND_REG, 1, KIND_VAR, 63);
        send_instr(OP_MUL, KIND_VAR, 63, 2'd2, 32'h7FFF_FFFF);
        send_instr(OP_INC, KIND_REG, 4, KIND_REG, 0);
        send_instr(OP_DEC, KIND_VAR, 0, KIND_REG, 0);
        send_instr(OP_PUSH, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_PUSHA, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_POPA, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_POP, KIND_VAR, 3, KIND_REG, 0);
        send_instr(OP_CMP, 2'd2, 3, 2'd2, 3);
        send_instr(OP_JGE, 2'd2, 100, KIND_REG, 0);
        send_instr(OP_JLE, 2'd2, 200, KIND_REG, 0);
        send_instr(OP_CALL, 2'd2, 32'h1_FFFF, KIND_REG, 0);
        send_instr(OP_RET, KIND_REG, 0, KIND_REG, 0);
        send_instr(5'd31, KIND_REG, 0, KIND_REG, 0);
    endtask

    // Fills the stack to the top, then overflows it both ways, then empties it.
    task automatic test_stack_limits();
        while (sp < STACK_N)
            send_instr(OP_PUSH, 2'd2, $urandom, KIND_REG, 0);
        send_instr(OP_PUSH, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_PUSHA, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_POPA, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_PUSHA, KIND_REG, 0, KIND_REG, 0);
        send_instr(OP_PUSHA, KIND_REG, 0, KIND_REG, 0);
        while (sp > 0)
            send_instr(OP_POP, KIND_VAR, $urandom_range(0, VAR_N - 1), KIND_REG, 0);
        drain_results();
    endtask

    task automatic test_random(int count);
        logic [4:0] op;
        logic [1:0] fk;
        logic [1:0] sk;
        logic [31:0] fv;
        for (int n = 0; n < count; n++)
        begin
            op = 5'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 20));
            fk = 2'($urandom_range(0, 9) == 0 ? $urandom_range(2, 3) : $urandom_range(0, 1));
            sk = 2'($urandom_range(0, 3));
            fv = dest_index(fk);
            send_instr(op, fk, fv, sk, (sk < 2) ? dest_index(sk) : rand_word());
            if (n == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sink_stall_on = 1'b0;
        errors = 0;
        mismatches = 0;
        for (int i = 0; i < REG_COUNT; i++) regs[i] = 32'd0;
        for (int i = 0; i < VAR_N; i++) vars[i] = 32'd0;
        sp = 0;
        cmp_val = 32'd0;
        pc = 16'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        sink_stall_on = 1'b1;
        test_stack_limits();
        sink_stall_on = 1'b0;
        test_random(150);
        sink_stall_on = 1'b1;
        test_random(150);
        drain_results();
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: errors");
        $finish;
    end

endmodule
